// ----- rtl/assert_macros.svh -----
// Assertion macros used by the pid step core top level.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pidcs_pkg.sv -----
// Package for the pid step core: types, register map, limit clamp.
// No dependencies; used by every module in rtl.
`timescale 1ns / 1ps
`default_nettype none

package pidcs_pkg;

    // Configuration port geometry
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_IDX_W = 3;

    // Register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd5;

    localparam logic [31:0] LIMIT_HIGH_RESET = 32'd65535;
    localparam logic [31:0] LIMIT_LOW_RESET  = 32'd0;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_MODE   = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [15:0] setpoint;
        logic [7:0]  gain_p_code;
        logic [7:0]  gain_i_code;
        logic [7:0]  gain_d_code;
        logic [31:0] limit_high;
        logic [31:0] limit_low;
    } cfg_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [15:0] sample;
        logic        enable_request;
    } item_t;

    typedef struct packed {
        logic        updated;
        logic [23:0] drive;
        logic        active;
    } result_t;

    // Clamp a wide sum to the limits; upper limit is tested first
    function automatic logic [31:0] clamp_lim(input logic signed [33:0] x,
                                              input logic signed [31:0] hi,
                                              input logic signed [31:0] lo);
        logic signed [33:0] hi_x;
        logic signed [33:0] lo_x;
        logic [31:0]        res;
        hi_x = {{2{hi[31]}}, hi};
        lo_x = {{2{lo[31]}}, lo};
        priority if (x > hi_x)
            res = hi;
        else if (x < lo_x)
            res = lo;
        else
            res = x[31:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pidcs_cfg_regs.sv -----
// APB-style configuration registers for the pid step core.
// Depends on pidcs_pkg for the register map and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module pidcs_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pidcs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pidcs_pkg::DATA_W-1:0] pwdata,
    output logic      [pidcs_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output pidcs_pkg::cfg_t                  cfg
);
    import pidcs_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SETPOINT:   cfg_next.setpoint    = pwdata[15:0];
                REG_GAIN_P:     cfg_next.gain_p_code = pwdata[7:0];
                REG_GAIN_I:     cfg_next.gain_i_code = pwdata[7:0];
                REG_GAIN_D:     cfg_next.gain_d_code = pwdata[7:0];
                REG_LIMIT_HIGH: cfg_next.limit_high  = pwdata;
                REG_LIMIT_LOW:  cfg_next.limit_low   = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint    <= '0;
            cfg_reg.gain_p_code <= '0;
            cfg_reg.gain_i_code <= '0;
            cfg_reg.gain_d_code <= '0;
            cfg_reg.limit_high  <= LIMIT_HIGH_RESET;
            cfg_reg.limit_low   <= LIMIT_LOW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_SETPOINT:   prdata = {16'd0, cfg_reg.setpoint};
            REG_GAIN_P:     prdata = {24'd0, cfg_reg.gain_p_code};
            REG_GAIN_I:     prdata = {24'd0, cfg_reg.gain_i_code};
            REG_GAIN_D:     prdata = {24'd0, cfg_reg.gain_d_code};
            REG_LIMIT_HIGH: prdata = cfg_reg.limit_high;
            REG_LIMIT_LOW:  prdata = cfg_reg.limit_low;
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/pidcs_step_unit.sv -----
// PID state and combinational step datapath for the pid step core.
// Depends on pidcs_pkg for cfg_t, item_t, result_t and clamp_lim.
`timescale 1ns / 1ps
`default_nettype none

module pidcs_step_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pidcs_pkg::cfg_t  cfg,
    input  wire pidcs_pkg::item_t item,
    input  wire logic             fire,
    output pidcs_pkg::result_t    result
);
    import pidcs_pkg::*;

    logic        active_reg;
    logic        active_next;
    logic [31:0] integral_reg;
    logic [31:0] integral_next;
    logic [15:0] prev_sample_reg;
    logic [15:0] prev_sample_next;
    logic [23:0] drive_hold_reg;
    logic [23:0] drive_hold_next;

    logic signed [7:0]  kp;
    logic signed [7:0]  ki;
    logic signed [7:0]  kd;
    logic signed [15:0] err;
    logic signed [15:0] dmeas;
    logic signed [23:0] p_term;
    logic signed [23:0] i_term;
    logic signed [23:0] d_term;
    logic signed [33:0] integral_acc;
    logic [31:0]        integral_clamped;
    logic [31:0]        integral_zero;
    logic signed [33:0] sum_acc;
    logic [31:0]        sum_clamped;

    // Gain decode: negate, with shifts for I and D, kept to 8 bits
    assign kp = 8'd0 - cfg.gain_p_code;
    assign ki = 8'd0 - {cfg.gain_i_code[6:0], 1'b0};
    assign kd = 8'd0 - {1'b0, cfg.gain_d_code[7:1]};

    // Error and derivative on measurement, wrapped to 16 bits
    assign err   = cfg.setpoint - item.sample;
    assign dmeas = item.sample - prev_sample_reg;

    assign p_term = kp * err;
    assign i_term = ki * err;
    assign d_term = kd * dmeas;

    // Integral update then clamped sum
    assign integral_acc = {{2{integral_reg[31]}}, integral_reg}
                        + {{10{i_term[23]}}, i_term};
    assign integral_clamped = clamp_lim(integral_acc, cfg.limit_high, cfg.limit_low);
    assign integral_zero    = clamp_lim('0, cfg.limit_high, cfg.limit_low);

    assign sum_acc = {{10{p_term[23]}}, p_term}
                   + {{2{integral_clamped[31]}}, integral_clamped}
                   - {{10{d_term[23]}}, d_term};
    assign sum_clamped = clamp_lim(sum_acc, cfg.limit_high, cfg.limit_low);

    // Next state per item kind
    always_comb
    begin
        active_next      = active_reg;
        integral_next    = integral_reg;
        prev_sample_next = prev_sample_reg;
        drive_hold_next  = drive_hold_reg;
        result.updated   = 1'b0;
        unique case (item.opcode)
            OP_MODE:
            begin
                if (item.enable_request && !active_reg)
                begin
                    integral_next    = integral_zero;
                    prev_sample_next = item.sample;
                end
                active_next = !active_reg;
            end
            OP_SAMPLE:
            begin
                if (active_reg)
                begin
                    integral_next    = integral_clamped;
                    prev_sample_next = item.sample;
                    // floor shift by 8 is the top 24 bits
                    drive_hold_next  = sum_clamped[31:8];
                    result.updated   = 1'b1;
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
        result.drive  = drive_hold_next;
        result.active = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            integral_reg    <= '0;
            prev_sample_reg <= '0;
            drive_hold_reg  <= '0;
        end
        else if (fire)
        begin
            active_reg      <= active_next;
            integral_reg    <= integral_next;
            prev_sample_reg <= prev_sample_next;
            drive_hold_reg  <= drive_hold_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pid_controller_step_core.sv -----
// Top level of the pid step core: input register, step unit, result register.
// Depends on pidcs_pkg, pidcs_cfg_regs, pidcs_step_unit and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Integer PID step with derivative on measurement. One item is taken per
// clock while in_stall is low; each item passes from the input register
// through the step stage, which writes the result register when the
// result side is free. In the step stage the integral feedback (multiply,
// add, clamp, then the clamped sum) closes combinationally between the
// state registers. Every item, sample or mode toggle, gives exactly one
// result. When the result side stalls, one further item is held in the
// input register before in_stall rises. Configuration is to be written over
// the APB-style port at byte address 4 * index only while no item is in
// flight; the block does not enforce this. No clearing pass follows reset.
module pid_controller_step_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pidcs_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pidcs_pkg::DATA_W-1:0] pwdata,
    output logic      [pidcs_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    // input channel
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        opcode,
    input  wire logic [15:0]                 sample,
    input  wire logic                        enable_request,
    // output channel
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             updated,
    output logic signed [23:0]               drive,
    output logic                             active
);
    import pidcs_pkg::*;

`include "assert_macros.svh"

    cfg_t    cfg;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t step_res;
    logic    adv_out;
    logic    fire;
    logic    in_xfer;

    pidcs_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidcs_step_unit u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (s1_item_reg),
        .fire   (fire),
        .result (step_res)
    );

    // Pipeline advance: result register frees when empty or taken
    assign adv_out  = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && adv_out;
    assign in_stall = s1_valid_reg && !adv_out;
    assign in_xfer  = in_valid && !in_stall;

    assign s1_valid_next  = in_stall ? 1'b1 : in_valid;
    assign out_valid_next = adv_out ? fire : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register captures each transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.opcode         <= opcode_t'(opcode);
            s1_item_reg.sample         <= sample;
            s1_item_reg.enable_request <= enable_request;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign updated   = res_reg.updated;
    assign drive     = res_reg.drive;
    assign active    = res_reg.active;

    // Checks
    `ASSERT_CLK(a_stall_needs_item, !in_stall || s1_valid_reg, "stall with empty stage")
    `ASSERT_NEXT(a_item_reaches_out, s1_valid_reg && !out_valid_reg, out_valid_reg, "item stuck")
    `ASSERT_CLK(a_updated_active, !out_valid_reg || !updated || active, "update while inactive")
    `ASSERT_NEXT(a_stall_holds_item, in_stall, s1_valid_reg && $stable(s1_item_reg), "item lost")

endmodule

`default_nettype wire
